@@ hdl/assert_macros.svh @@
// Assertion helpers used by the checker file.
// All checks sample on the rising edge of aclk and are off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property every cycle outside reset.
`define CHK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another condition in the next cycle.
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/slic_pkg.sv @@
// ---------------------------------------------------------------------------
// slic_pkg
// Shared types and codes for the sorted list intersection counter.
// ---------------------------------------------------------------------------
`default_nettype none

package slic_pkg;

    // Action codes carried on the input channel
    typedef enum logic [1:0] {
        ACT_FIRST  = 2'd0,
        ACT_SECOND = 2'd1,
        ACT_START  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_WALK = 2'd1,
        ST_DONE = 2'd2
    } state_t;

    localparam int COUNT_W = 11;

    // Commands from controller to datapath
    typedef struct packed {
        logic load_first;
        logic load_second;
        logic walk_init;
        logic walk_step;
        logic finish;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

@@ hdl/slic_ctrl.sv @@
// ---------------------------------------------------------------------------
// slic_ctrl
// Controller: accepts transfers in idle, sequences the merge walk and the
// result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module slic_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    input  wire logic [1:0]      s_action,
    output logic                 s_ready,
    input  slic_pkg::status_t    status,
    output slic_pkg::cmd_t       cmd
);
    import slic_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next      = state_reg;
        s_ready         = 1'b0;
        accept          = 1'b0;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
                if (accept) begin
                    unique case (action_t'(s_action))
                        ACT_FIRST:  cmd.load_first  = 1'b1;
                        ACT_SECOND: cmd.load_second = 1'b1;
                        ACT_START: begin
                            cmd.walk_init = 1'b1;
                            state_next    = ST_WALK;
                        end
                        ACT_NONE:   ;
                        default:    ;
                    endcase
                end
            end
            ST_WALK: begin
                if (status.walk_done) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DONE: begin
                // wait until the output register is free
                if (!status.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

@@ hdl/slic_dpath.sv @@
// ---------------------------------------------------------------------------
// slic_dpath
// Datapath: the two list memories, their lengths, the walk pointers, the
// compare and count logic, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module slic_dpath #(
    parameter int LIST_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [31:0]                   s_value,
    input  slic_pkg::cmd_t                     cmd,
    output slic_pkg::status_t                  status,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [slic_pkg::COUNT_W-1:0]       m_match_count,
    output logic                               m_overflowed
);
    import slic_pkg::*;

    localparam int LEN_W  = $clog2(LIST_DEPTH + 1);
    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(LIST_DEPTH);

    logic [31:0]        first_mem  [LIST_DEPTH];
    logic [31:0]        second_mem [LIST_DEPTH];

    logic [LEN_W-1:0]   first_len_reg, first_len_next;
    logic [LEN_W-1:0]   second_len_reg, second_len_next;
    logic               ovf_reg, ovf_next;
    logic               first_wr, second_wr;

    logic [LEN_W-1:0]   ptr_a_reg, ptr_a_next;
    logic [LEN_W-1:0]   ptr_b_reg, ptr_b_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [31:0]        data_a_reg, data_b_reg;
    logic               a_le_b, b_le_a;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_ovf_reg;

    // Append and job-clear control
    always_comb begin
        first_len_next  = first_len_reg;
        second_len_next = second_len_reg;
        ovf_next        = ovf_reg;
        first_wr        = 1'b0;
        second_wr       = 1'b0;
        priority if (cmd.finish) begin
            first_len_next  = '0;
            second_len_next = '0;
            ovf_next        = 1'b0;
        end else if (cmd.load_first) begin
            if (first_len_reg < DEPTH_L) begin
                first_wr       = 1'b1;
                first_len_next = first_len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end else if (cmd.load_second) begin
            if (second_len_reg < DEPTH_L) begin
                second_wr       = 1'b1;
                second_len_next = second_len_reg + LEN_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_len_reg  <= '0;
            second_len_reg <= '0;
            ovf_reg        <= 1'b0;
        end else begin
            first_len_reg  <= first_len_next;
            second_len_reg <= second_len_next;
            ovf_reg        <= ovf_next;
        end
    end

    // List memories: one write, one registered read each
    always_ff @(posedge aclk) begin
        if (first_wr) begin
            first_mem[first_len_reg[ADDR_W-1:0]] <= s_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (second_wr) begin
            second_mem[second_len_reg[ADDR_W-1:0]] <= s_value;
        end
    end

    // read ahead at the pointer values of the next cycle
    always_ff @(posedge aclk) begin
        data_a_reg <= first_mem[ptr_a_next[ADDR_W-1:0]];
        data_b_reg <= second_mem[ptr_b_next[ADDR_W-1:0]];
    end

    // Merge step: advance the smaller side, both on a match
    assign a_le_b = (data_a_reg <= data_b_reg);
    assign b_le_a = (data_b_reg <= data_a_reg);

    always_comb begin
        ptr_a_next = ptr_a_reg;
        ptr_b_next = ptr_b_reg;
        count_next = count_reg;
        priority if (cmd.walk_init) begin
            ptr_a_next = '0;
            ptr_b_next = '0;
            count_next = '0;
        end else if (cmd.walk_step) begin
            if (a_le_b) begin
                ptr_a_next = ptr_a_reg + LEN_W'(1);
            end
            if (b_le_a) begin
                ptr_b_next = ptr_b_reg + LEN_W'(1);
            end
            if (a_le_b && b_le_a) begin
                count_next = count_reg + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        ptr_a_reg <= ptr_a_next;
        ptr_b_reg <= ptr_b_next;
        count_reg <= count_next;
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_count_reg <= count_reg;
            out_ovf_reg   <= ovf_reg;
        end
    end

    assign status.walk_done = (ptr_a_reg >= first_len_reg) || (ptr_b_reg >= second_len_reg);
    assign status.out_busy  = out_valid_reg && !m_ready;

    assign m_valid       = out_valid_reg;
    assign m_match_count = out_count_reg;
    assign m_overflowed  = out_ovf_reg;

endmodule

`default_nettype wire

@@ hdl/sorted_list_intersection_count.sv @@
// ---------------------------------------------------------------------------
// sorted_list_intersection_count
// Counts the values shared by two ascending lists by a merge walk.
// ---------------------------------------------------------------------------
// Channel  Direction  Ports                               Transfer
// s_       in         s_action, s_value                   s_valid & s_ready
// m_       out        m_match_count, m_overflowed         m_valid & m_ready
//
// Load transfers are taken back to back in idle.
// A start transfer holds the input through the accept cycle, the walk
// cycles (the last one sees a list run out) and the finish cycle; the walk
// takes at most first length + second length steps. The merge walk does
// one step per cycle, limited by the registered read port of each list memory.
// Loads for the next job are taken while a result waits in the output
// register; a further start walks, then holds in its finish cycle until
// that result has been transferred.
// Reset (aresetn, synchronous) empties both lists and clears the flag.
// ---------------------------------------------------------------------------
`default_nettype none

module sorted_list_intersection_count #(
    parameter int LIST_DEPTH = 1024
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [1:0]                    s_action,
    input  wire logic [31:0]                   s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [slic_pkg::COUNT_W-1:0]       m_match_count,
    output logic                               m_overflowed
);
    import slic_pkg::*;

    cmd_t    cmd;
    status_t status;

    slic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    slic_dpath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_value       (s_value),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_match_count (m_match_count),
        .m_overflowed  (m_overflowed)
    );

endmodule

`default_nettype wire

@@ hdl/slic_checker.sv @@
// ---------------------------------------------------------------------------
// slic_checker
// Port-level checks for the sorted list intersection counter.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module slic_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic [1:0]  s_action,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [10:0] m_match_count,
    input wire logic        m_overflowed
);
    import slic_pkg::*;

    logic start_xfer;

    assign start_xfer   = s_valid && s_ready && (s_action == ACT_START);

    // a pending result holds until transferred
    `CHK_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_match_count) && $stable(m_overflowed), "result changed while stalled")

    // the walk blocks new transfers right after a start
    `CHK_NEXT(a_start_busy, start_xfer, !s_ready, "input taken during walk")

    // a new result only appears at the end of a walk
    `CHK_ALWAYS(a_result_after_walk, $rose(m_valid) |-> $past(!s_ready), "result without walk")

endmodule

bind sorted_list_intersection_count slic_checker u_slic_checker (.*);

`default_nettype wire
